@@ rtl/core/spq_pkg.sv @@
package spq_pkg;

  // Queue depth and derived widths.
  localparam int CAPACITY = 16;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Valid priority range, highest value leaves first.
  localparam logic [3:0] PRIO_MIN = 4'd1;
  localparam logic [3:0] PRIO_MAX = 4'd10;

  // Request operation codes.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_POPPED = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_BADPRIO = 3'd4;

  // Request payload.
  typedef struct packed {
    logic        cmd;
    logic [63:0] in_value;
    logic [3:0]  in_priority;
  } spq_in_t;

  // Result payload.
  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] out_value;
    logic [3:0]  out_priority;
    logic [4:0]  occupancy;
  } spq_out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_req;
    logic exec;
  } spq_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_busy;
  } spq_stat_t;

endpackage

@@ rtl/core/stable_priority_queue.sv @@
// Stable priority queue, priorities 1 to 10, highest first, FIFO within a level.
// Request channel: in_valid/in_ready with in_data (cmd, in_value, in_priority).
// cmd selects insert or pop; a pop ignores in_value and in_priority.
// Result channel: out_valid/out_ready with out_data (status, out_value,
// out_priority, occupancy); every request gives exactly one result.
// A request is taken in the idle state and run in the execute state once
// the result register is free; its result is registered when it runs, and
// the queue takes no new request until the previous one has run. All
// slots compare with the new priority in parallel and shift together;
// the controller's take and execute states set the pace.
// A request may be accepted while the previous result still waits; if the
// receiver stalls, execution holds until that result is taken, and
// in_ready stays low meanwhile.
// Reset (rst, synchronous) empties the queue and drops any pending result;
// slot contents are not cleared, only the entry count.
module stable_priority_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  spq_pkg::spq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output spq_pkg::spq_out_t out_data
);

  spq_pkg::spq_cmd_t  cmd;
  spq_pkg::spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/core/spq_ctrl.sv @@
module spq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  spq_pkg::spq_stat_t stat,
  output spq_pkg::spq_cmd_t  cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  // Take a request in idle, then run it once the result register is free.
  always_comb begin
    state_next = state;
    cmd.load_req = 1'b0;
    cmd.exec = 1'b0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!stat.out_busy) begin
          cmd.exec = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/core/spq_datapath.sv @@
module spq_datapath (
  input  logic              clk,
  input  logic              rst,
  input  spq_pkg::spq_in_t  in_data,
  input  spq_pkg::spq_cmd_t cmd,
  output spq_pkg::spq_stat_t stat,
  output logic              out_valid,
  input  logic              out_ready,
  output spq_pkg::spq_out_t out_data
);

  localparam int CAP = spq_pkg::CAPACITY;
  localparam int CW = spq_pkg::CNT_W;

  // Sorted entry array, head at slot 0.
  logic [63:0]   value [CAP];
  logic [3:0]    prio [CAP];
  logic [CW-1:0] count;
  spq_pkg::spq_in_t req;

  logic [CAP-1:0] lower;
  logic [CAP-1:0] ins_here;
  logic           bad_prio;
  logic           is_full;
  logic           is_empty;
  logic           do_insert;
  logic           do_pop;
  spq_pkg::spq_out_t result;

  // Request classification.
  assign bad_prio = (req.in_priority < spq_pkg::PRIO_MIN) ||
                    (req.in_priority > spq_pkg::PRIO_MAX);
  assign is_full = (count == CW'(CAP));
  assign is_empty = (count == '0);
  assign do_insert = cmd.exec && (req.cmd == spq_pkg::CMD_INSERT) && !bad_prio && !is_full;
  assign do_pop = cmd.exec && (req.cmd == spq_pkg::CMD_POP) && !is_empty;

  // Every held slot compares its priority with the new one in parallel.
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      lower[i] = (CW'(i) < count) && (prio[i] < req.in_priority);
      ins_here[i] = lower[i] || (CW'(i) == count);
    end
  end

  // Insert shifts the tail down by one; pop shifts everything up by one.
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAP; i++) begin
      if (do_insert && ins_here[i]) begin
        if (i > 0 && ins_here[(i > 0) ? i - 1 : 0]) begin
          value[i] <= value[(i > 0) ? i - 1 : 0];
          prio[i] <= prio[(i > 0) ? i - 1 : 0];
        end else begin
          value[i] <= req.in_value;
          prio[i] <= req.in_priority;
        end
      end else if (do_pop && i < CAP - 1) begin
        value[i] <= value[(i < CAP - 1) ? i + 1 : i];
        prio[i] <= prio[(i < CAP - 1) ? i + 1 : i];
      end
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_insert) begin
      count <= count + 1'b1;
    end else if (do_pop) begin
      count <= count - 1'b1;
    end
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req <= in_data;
    end
  end

  // Result formation.
  always_comb begin
    result.out_value = '0;
    result.out_priority = '0;
    result.occupancy = 5'(count);
    if (req.cmd == spq_pkg::CMD_INSERT) begin
      if (bad_prio) begin
        result.status = spq_pkg::ST_BADPRIO;
      end else if (is_full) begin
        result.status = spq_pkg::ST_FULL;
      end else begin
        result.status = spq_pkg::ST_INSERTED;
        result.occupancy = 5'(count + 1'b1);
      end
    end else if (is_empty) begin
      result.status = spq_pkg::ST_EMPTY;
    end else begin
      result.status = spq_pkg::ST_POPPED;
      result.out_value = value[0];
      result.out_priority = prio[0];
      result.occupancy = 5'(count - 1'b1);
    end
  end

  // Output register holds the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_data <= result;
    end
  end

  assign stat.out_busy = out_valid && !out_ready;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAP)) else $error("entry count above capacity");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> !(out_valid && !out_ready)) else $error("result overwritten");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    do_insert |=> count == $past(count) + 1'b1) else $error("insert count slip");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    (count >= CW'(2)) |-> prio[0] >= prio[1]) else $error("head out of order");
`endif

endmodule

@@ tb/sv/spq_checker.sv @@
module spq_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  spq_pkg::spq_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  spq_pkg::spq_out_t out_data,
  output int                fail_count,
  output int                pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] value;
    logic [3:0]  prio;
  } held_entry_t;

  // Entries held by the queue, head first, and the results still owed.
  held_entry_t       held_entries[$];
  spq_pkg::spq_out_t expected_results[$];

  // Applies one request to the local copy of the queue and returns its result.
  function automatic spq_pkg::spq_out_t apply_request(spq_pkg::spq_in_t req);
    spq_pkg::spq_out_t res;
    held_entry_t       entry;
    int                pos;
    res = '0;
    if (req.cmd == spq_pkg::CMD_INSERT) begin
      if (req.in_priority < spq_pkg::PRIO_MIN || req.in_priority > spq_pkg::PRIO_MAX) begin
        res.status = spq_pkg::ST_BADPRIO;
      end else if (held_entries.size() >= spq_pkg::CAPACITY) begin
        res.status = spq_pkg::ST_FULL;
      end else begin
        // The new entry goes ahead of the first strictly lower priority.
        pos = held_entries.size();
        for (int i = 0; i < held_entries.size(); i++) begin
          if (pos == held_entries.size() && held_entries[i].prio < req.in_priority) begin
            pos = i;
          end
        end
        entry.value = req.in_value;
        entry.prio  = req.in_priority;
        held_entries.insert(pos, entry);
        res.status = spq_pkg::ST_INSERTED;
      end
    end else if (held_entries.size() == 0) begin
      res.status = spq_pkg::ST_EMPTY;
    end else begin
      entry = held_entries.pop_front();
      res.status       = spq_pkg::ST_POPPED;
      res.out_value    = entry.value;
      res.out_priority = entry.prio;
    end
    res.occupancy = 5'(held_entries.size());
    return res;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Results are checked before the request of the same edge is predicted.
  always @(posedge clk) begin
    spq_pkg::spq_out_t exp_res;
    if (rst) begin
      held_entries.delete();
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          fail_count++;
        end else begin
          exp_res = expected_results.pop_front();
          check_field("status", 64'(exp_res.status), 64'(out_data.status));
          check_field("out_value", exp_res.out_value, out_data.out_value);
          check_field("out_priority", 64'(exp_res.out_priority),
                      64'(out_data.out_priority));
          check_field("occupancy", 64'(exp_res.occupancy), 64'(out_data.occupancy));
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_request(in_data));
      end
    end
    pending_results = expected_results.size();
  end

endmodule

@@ tb/sv/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 800;
  localparam int HOLD_CYCLES  = 200;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              out_ready = 1'b0;
  spq_pkg::spq_in_t  in_data   = '0;
  logic              in_ready;
  logic              out_valid;
  spq_pkg::spq_out_t out_data;

  int fail_count;
  int pending_results;
  int cycle_count = 0;
  int items_sent  = 0;
  bit no_idle       = 1'b0;
  bit long_hold_req = 1'b0;

  stable_priority_queue DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  spq_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Idle length: mostly short, now and then long.
  function automatic int idle_gap(int shortest);
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return shortest;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand_value();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Priority 0 or 11 to 15.
  function automatic logic [3:0] bad_priority();
    int r;
    r = $urandom_range(0, 5);
    return (r == 0) ? 4'd0 : 4'(10 + r);
  endfunction

  function automatic spq_pkg::spq_in_t make_insert(logic [63:0] value, logic [3:0] prio);
    spq_pkg::spq_in_t req;
    req.cmd         = spq_pkg::CMD_INSERT;
    req.in_value    = value;
    req.in_priority = prio;
    return req;
  endfunction

  // Pop requests carry junk in the ignored fields.
  function automatic spq_pkg::spq_in_t make_pop();
    spq_pkg::spq_in_t req;
    req.cmd         = spq_pkg::CMD_POP;
    req.in_value    = rand_value();
    req.in_priority = 4'($urandom_range(0, 15));
    return req;
  endfunction

  // Offers one request from a falling edge until it is accepted.
  task automatic send_req(input spq_pkg::spq_in_t req);
    int gap;
    in_data  = req;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
    gap = idle_gap(0);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  // Runs past capacity, then a bad priority while full.
  task automatic fill_burst();
    repeat (spq_pkg::CAPACITY + 2) begin
      send_req(make_insert(rand_value(), 4'($urandom_range(1, 10))));
    end
    send_req(make_insert(rand_value(), bad_priority()));
  endtask

  task automatic mixed_burst(input int count);
    int r;
    int hi;
    hi = $urandom_range(1, 10);
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send_req(make_insert(rand_value(), bad_priority()));
      end else if (r < 60) begin
        // A narrow priority band per burst stresses ordering within a level.
        send_req(make_insert(rand_value(), 4'($urandom_range(1, hi))));
      end else begin
        send_req(make_pop());
      end
    end
  endtask

  // Receiver: random stretches of ready and stall, or a long hold on request.
  initial begin
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold_req = 1'b0;
      end else if (no_idle) begin
        out_ready = 1'b1;
        @(negedge clk);
      end else if ($urandom_range(0, 99) < 70) begin
        out_ready = 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        out_ready = 1'b0;
        repeat (idle_gap(1)) @(negedge clk);
      end
    end
  end

  // Sender: directed requests, then random bursts, then the verdict.
  initial begin
    int burst_no;
    int r;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Empty pop, bad priorities, both ends of the value and priority range.
    send_req(make_pop());
    send_req(make_insert(rand_value(), 4'd0));
    send_req(make_insert(rand_value(), 4'd11));
    send_req(make_insert(rand_value(), 4'd15));
    send_req(make_insert(64'h0, spq_pkg::PRIO_MIN));
    send_req(make_insert('1, spq_pkg::PRIO_MAX));
    send_req(make_insert(rand_value(), 4'd5));
    send_req(make_insert(64'h5555_5555_5555_5555, spq_pkg::PRIO_MAX));
    send_req(make_insert(64'hAAAA_AAAA_AAAA_AAAA, spq_pkg::PRIO_MIN));
    repeat (6) send_req(make_pop());
    wait_drained();

    // Random bursts; two of them fill the queue behind a long receiver hold.
    items_sent = 0;
    burst_no   = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (burst_no == 0 || burst_no == 12) begin
        long_hold_req = 1'b1;
        fill_burst();
        wait_drained();
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          fill_burst();
        end else if (r < 25) begin
          repeat (spq_pkg::CAPACITY + 2) send_req(make_pop());
        end else if (r < 35) begin
          no_idle = 1'b1;
          mixed_burst(40);
          no_idle = 1'b0;
        end else if (r < 40) begin
          wait_drained();
        end else begin
          mixed_burst($urandom_range(10, 40));
        end
      end
      burst_no++;
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/spq_pkg.sv
rtl/core/spq_ctrl.sv
rtl/core/spq_datapath.sv
rtl/core/stable_priority_queue.sv
tb/sv/spq_checker.sv
tb/sv/tb.sv
